[rtl/ac_power_window_accumulator_assert.svh]
// assertion macros for the ac power window accumulator
`ifndef AC_POWER_WINDOW_ACCUMULATOR_ASSERT_SVH
`define AC_POWER_WINDOW_ACCUMULATOR_ASSERT_SVH
`ifndef SYNTHESIS
`define APWA_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define APWA_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);
`else
`define APWA_ASSERT(lbl, clk, rstn, prop, msg)
`define APWA_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

[rtl/apwa_pkg.sv]
// shared constants and types of the ac power window accumulator
`default_nettype none
package apwa_pkg;
    localparam int ADC_BITS   = 12;
    localparam int Q_SH       = 10;
    localparam int OFF_W      = ADC_BITS + Q_SH;
    localparam int FV_W       = OFF_W + 1;
    localparam int PC_W       = 15;
    localparam int PC_SH      = 14;
    localparam int XC_W       = 10;
    localparam int CNT_W      = 16;
    localparam int TO_W       = 16;
    localparam int ACC_W      = 64;
    localparam int MUL_W      = FV_W + 3;
    localparam int OP_W       = MUL_W + 1;
    localparam int PROD_W     = 2 * MUL_W + 2;
    localparam int MCNT_W     = $clog2(MUL_W + 1);
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 16;
    localparam int S_DATA_W   = 32;
    localparam int M_DATA_W   = 216;
    localparam int FULL       = 1 << ADC_BITS;
    localparam int V_LOW      = (FULL * 45) / 100;
    localparam int V_HIGH     = (FULL * 55 - 1) / 100;

    localparam logic [CFG_ADDR_W-1:0] CFG_TARGET  = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_TIMEOUT = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_PHASE   = 2'd2;

    typedef enum logic [1:0] {PH_IDLE, PH_WAIT, PH_MEAS} phase_t;
    typedef enum logic {ST_IDLE, ST_RUN} st_t;
    typedef enum logic [1:0] {OP_VSQ, OP_ASQ, OP_SHIFT, OP_PWR} op_t;
endpackage
`default_nettype wire

[rtl/apwa_mul.sv]
// bit-serial signed multiplier, one multiplier bit per cycle
`default_nettype none
module apwa_mul (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               start,
    input  wire logic signed [apwa_pkg::OP_W-1:0]   a,
    input  wire logic signed [apwa_pkg::OP_W-1:0]   b,
    output logic                                    busy,
    output logic                                    done,
    output logic signed [apwa_pkg::PROD_W-1:0]     product
);
    import apwa_pkg::*;

    logic [MCNT_W-1:0]  cnt_reg, cnt_next;
    logic               neg_reg, neg_next;
    logic               done_reg, done_next;
    logic [MUL_W-1:0]   mag_reg, mag_next;
    logic [2*MUL_W-1:0] p_reg, p_next;
    logic [OP_W-1:0]    a_abs, b_abs;
    logic [MUL_W:0]     sum;

    always_comb
    begin
        a_abs     = a[OP_W-1] ? OP_W'(-a) : OP_W'(a);
        b_abs     = b[OP_W-1] ? OP_W'(-b) : OP_W'(b);
        sum       = {1'b0, p_reg[2*MUL_W-1:MUL_W]}
                  + (p_reg[0] ? {1'b0, mag_reg} : {(MUL_W+1){1'b0}});
        cnt_next  = cnt_reg;
        neg_next  = neg_reg;
        mag_next  = mag_reg;
        p_next    = p_reg;
        done_next = 1'b0;
        if (cnt_reg != '0)
        begin
            p_next    = {sum, p_reg[MUL_W-1:1]};
            cnt_next  = cnt_reg - 1'b1;
            done_next = (cnt_reg == MCNT_W'(1));
        end
        else if (start)
        begin
            neg_next = a[OP_W-1] ^ b[OP_W-1];
            mag_next = a_abs[MUL_W-1:0];
            p_next   = {{MUL_W{1'b0}}, b_abs[MUL_W-1:0]};
            cnt_next = MCNT_W'(MUL_W);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg <= neg_next;
        mag_reg <= mag_next;
        p_reg   <= p_next;
    end

    assign busy    = (cnt_reg != '0);
    assign done    = done_reg;
    assign product = neg_reg ? -$signed({2'b00, p_reg}) : $signed({2'b00, p_reg});
endmodule
`default_nettype wire

[rtl/ac_power_window_accumulator.sv]
// top level of the ac power window accumulator
// usage:
//   s_* carries sample requests (start flag, voltage, current, millisecond tick);
//   m_* carries one window result (three 64-bit sums, sample count, timeout flag).
//   cfg_we/cfg_addr/cfg_wdata write crossing target, timeout and phase factor;
//   the user must do so only while the block is idle; the block does not enforce it.
// timing:
//   idle and wait requests do not use the multiplier. a measured request runs four
//   products through one bit-serial multiplier of 26 steps each; new requests
//   wait until the last product is done.
//   a result appears in the output register the cycle after the request that
//   ends the window, or after the last product when the crossing target is met.
// reset clears phase, offsets, sums and counters; configuration returns to
//   20 crossings, 2000 ms, phase factor 27853.
// a stalled result holds in the output register; new requests wait until it
//   is taken or leaves in the same cycle.
`default_nettype none
`include "ac_power_window_accumulator_assert.svh"
module ac_power_window_accumulator (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    // start_req, volt_sample, amp_sample, ms_tick
    input  wire logic [apwa_pkg::S_DATA_W-1:0]       s_tdata,
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    // sum_volt_sq, sum_amp_sq, sum_power, sample_count, timed_out
    output logic [apwa_pkg::M_DATA_W-1:0]            m_tdata,
    input  wire logic                                cfg_we,
    input  wire logic [apwa_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  wire logic [apwa_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
    import apwa_pkg::*;

    phase_t                   phase_reg, phase_next;
    st_t                      st_reg, st_next;
    op_t                      op_reg, op_next;
    logic [OFF_W-1:0]         voff_reg, voff_next, aoff_reg, aoff_next;
    logic signed [FV_W-1:0]   prev_reg, prev_next, last_reg, last_next;
    logic signed [FV_W-1:0]   fv_reg, fv_next, fi_reg, fi_next;
    logic [ADC_BITS-1:0]      ref_reg, ref_next;
    logic                     above_reg, above_next;
    logic [XC_W-1:0]          xc_reg, xc_next, tgt_reg, tgt_next;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;
    logic [TO_W-1:0]          el_reg, el_next, to_reg, to_next;
    logic [PC_W-1:0]          pc_reg, pc_next;
    logic [ACC_W-1:0]         accv_reg, accv_next, acca_reg, acca_next;
    logic [ACC_W-1:0]         accp_reg, accp_next;
    logic                     ov_reg, ov_next, oto_reg, oto_next;
    logic [ACC_W-1:0]         osv_reg, osv_next, osa_reg, osa_next, osp_reg, osp_next;
    logic [CNT_W-1:0]         ocnt_reg, ocnt_next;

    logic                     accept, go, mul_start, mul_busy, mul_done;
    logic signed [OP_W-1:0]   mul_a, mul_b, shifted;
    logic signed [PROD_W-1:0] mul_prod, prod_sh;
    logic                     start_req, ms_tick;
    logic [ADC_BITS-1:0]      vs, as_s;
    logic signed [FV_W-1:0]   sc_v, sc_a, dif_v, dif_a, on_v, on_a, fv_now, fi_now;

    assign start_req = s_tdata[0];
    assign vs        = s_tdata[12:1];
    assign as_s      = s_tdata[24:13];
    assign ms_tick   = s_tdata[25];
    assign s_tready  = (st_reg == ST_IDLE) && (!ov_reg || m_tready);
    assign accept    = s_tvalid && s_tready;

    // offset trackers
    always_comb
    begin
        sc_v   = $signed({1'b0, vs, {Q_SH{1'b0}}});
        sc_a   = $signed({1'b0, as_s, {Q_SH{1'b0}}});
        dif_v  = sc_v - $signed({1'b0, voff_reg});
        dif_a  = sc_a - $signed({1'b0, aoff_reg});
        on_v   = $signed({1'b0, voff_reg}) + (dif_v >>> Q_SH);
        on_a   = $signed({1'b0, aoff_reg}) + (dif_a >>> Q_SH);
        fv_now = sc_v - on_v;
        fi_now = sc_a - on_a;
    end

    assign prod_sh = mul_prod >>> PC_SH;
    assign shifted = OP_W'(last_reg) + $signed(prod_sh[OP_W-1:0]);

    apwa_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .busy    (mul_busy),
        .done    (mul_done),
        .product (mul_prod)
    );

    // sequencer next state
    always_comb
    begin
        st_next = st_reg;
        op_next = op_reg;
        unique case (st_reg)
            ST_IDLE:
            begin
                if (go)
                begin
                    st_next = ST_RUN;
                    op_next = OP_VSQ;
                end
            end
            ST_RUN:
            begin
                if (mul_done)
                begin
                    if (op_reg == OP_PWR)
                        st_next = ST_IDLE;
                    else
                        op_next = op_t'(op_reg + 2'd1);
                end
            end
            default: st_next = ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        mul_start = 1'b0;
        mul_a     = OP_W'(fv_now);
        mul_b     = OP_W'(fv_now);
        unique case (st_reg)
            ST_IDLE:
                mul_start = go;
            ST_RUN:
            begin
                mul_start = mul_done && (op_reg != OP_PWR);
                unique case (op_reg)
                    OP_VSQ:
                    begin
                        mul_a = OP_W'(fi_reg);
                        mul_b = OP_W'(fi_reg);
                    end
                    OP_ASQ:
                    begin
                        mul_a = $signed({{(OP_W-PC_W){1'b0}}, pc_reg});
                        mul_b = OP_W'(fv_reg) - OP_W'(last_reg);
                    end
                    OP_SHIFT:
                    begin
                        mul_a = shifted;
                        mul_b = OP_W'(fi_reg);
                    end
                    OP_PWR:
                    begin
                        mul_a = OP_W'(fi_reg);
                        mul_b = OP_W'(fi_reg);
                    end
                    default:
                    begin
                        mul_a = OP_W'(fi_reg);
                        mul_b = OP_W'(fi_reg);
                    end
                endcase
            end
            default: mul_start = 1'b0;
        endcase
    end

    // window control and datapath
    always_comb
    begin
        phase_t           ph;
        logic [TO_W-1:0]  el;
        logic             tk;
        logic             now_above;
        logic             was_above;

        phase_next = phase_reg;
        voff_next  = voff_reg;
        aoff_next  = aoff_reg;
        prev_next  = prev_reg;
        last_next  = last_reg;
        fv_next    = fv_reg;
        fi_next    = fi_reg;
        ref_next   = ref_reg;
        above_next = above_reg;
        xc_next    = xc_reg;
        cnt_next   = cnt_reg;
        el_next    = el_reg;
        tgt_next   = tgt_reg;
        to_next    = to_reg;
        pc_next    = pc_reg;
        accv_next  = accv_reg;
        acca_next  = acca_reg;
        accp_next  = accp_reg;
        ov_next    = ov_reg && !m_tready;
        osv_next   = osv_reg;
        osa_next   = osa_reg;
        osp_next   = osp_reg;
        ocnt_next  = ocnt_reg;
        oto_next   = oto_reg;
        go         = 1'b0;
        ph         = phase_reg;
        el         = el_reg;
        tk         = ms_tick;
        now_above  = (vs > ref_reg);
        was_above  = (cnt_reg == '0) ? now_above : above_reg;

        if (cfg_we)
        begin
            unique case (cfg_addr)
                CFG_TARGET:  tgt_next = cfg_wdata[XC_W-1:0];
                CFG_TIMEOUT: to_next  = cfg_wdata[TO_W-1:0];
                CFG_PHASE:   pc_next  = cfg_wdata[PC_W-1:0];
                default:     tgt_next = tgt_reg;
            endcase
        end

        if (accept)
        begin
            if (start_req)
            begin
                accv_next  = '0;
                acca_next  = '0;
                accp_next  = '0;
                xc_next    = '0;
                cnt_next   = '0;
                above_next = 1'b0;
                el         = '0;
                tk         = 1'b0;
                ph         = PH_WAIT;
            end
            if (tk && el != '1)
                el = el + 1'b1;
            el_next    = el;
            phase_next = ph;
            unique case (ph)
                PH_IDLE: el_next = el_reg;
                PH_WAIT:
                begin
                    if ((vs > ADC_BITS'(V_LOW) && vs <= ADC_BITS'(V_HIGH)) || el > to_reg)
                    begin
                        ref_next   = vs;
                        el_next    = '0;
                        phase_next = PH_MEAS;
                    end
                end
                PH_MEAS:
                begin
                    if (xc_reg >= tgt_reg || el >= to_reg)
                    begin
                        ov_next    = 1'b1;
                        osv_next   = accv_reg;
                        osa_next   = acca_reg;
                        osp_next   = accp_reg;
                        ocnt_next  = cnt_reg;
                        oto_next   = !(xc_reg >= tgt_reg);
                        phase_next = PH_IDLE;
                    end
                    else
                    begin
                        go         = 1'b1;
                        cnt_next   = (cnt_reg != '1) ? cnt_reg + 1'b1 : cnt_reg;
                        voff_next  = on_v[OFF_W-1:0];
                        aoff_next  = on_a[OFF_W-1:0];
                        fv_next    = fv_now;
                        fi_next    = fi_now;
                        last_next  = prev_reg;
                        prev_next  = fv_now;
                        above_next = now_above;
                        if (was_above != now_above && xc_reg != '1)
                            xc_next = xc_reg + 1'b1;
                    end
                end
                default: phase_next = PH_IDLE;
            endcase
        end

        if (st_reg == ST_RUN && mul_done)
        begin
            unique case (op_reg)
                OP_VSQ:   accv_next = accv_reg + ACC_W'(mul_prod);
                OP_ASQ:   acca_next = acca_reg + ACC_W'(mul_prod);
                OP_SHIFT: accp_next = accp_reg;
                OP_PWR:
                begin
                    accp_next = accp_reg + ACC_W'(mul_prod);
                    if (xc_reg >= tgt_reg)
                    begin
                        ov_next    = 1'b1;
                        osv_next   = accv_reg;
                        osa_next   = acca_reg;
                        osp_next   = accp_reg + ACC_W'(mul_prod);
                        ocnt_next  = cnt_reg;
                        oto_next   = 1'b0;
                        phase_next = PH_IDLE;
                    end
                end
                default: accp_next = accp_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            st_reg    <= ST_IDLE;
            op_reg    <= OP_VSQ;
            voff_reg  <= '0;
            aoff_reg  <= '0;
            prev_reg  <= '0;
            ref_reg   <= '0;
            above_reg <= 1'b0;
            xc_reg    <= '0;
            cnt_reg   <= '0;
            el_reg    <= '0;
            tgt_reg   <= XC_W'(20);
            to_reg    <= TO_W'(2000);
            pc_reg    <= PC_W'(27853);
            accv_reg  <= '0;
            acca_reg  <= '0;
            accp_reg  <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            st_reg    <= st_next;
            op_reg    <= op_next;
            voff_reg  <= voff_next;
            aoff_reg  <= aoff_next;
            prev_reg  <= prev_next;
            ref_reg   <= ref_next;
            above_reg <= above_next;
            xc_reg    <= xc_next;
            cnt_reg   <= cnt_next;
            el_reg    <= el_next;
            tgt_reg   <= tgt_next;
            to_reg    <= to_next;
            pc_reg    <= pc_next;
            accv_reg  <= accv_next;
            acca_reg  <= acca_next;
            accp_reg  <= accp_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        last_reg <= last_next;
        fv_reg   <= fv_next;
        fi_reg   <= fi_next;
        osv_reg  <= osv_next;
        osa_reg  <= osa_next;
        osp_reg  <= osp_next;
        ocnt_reg <= ocnt_next;
        oto_reg  <= oto_next;
    end

    assign m_tvalid = ov_reg;
    assign m_tdata  = {7'b0, oto_reg, ocnt_reg, osp_reg, osa_reg, osv_reg};

    `APWA_ASSERT(a_ready_idle_mul, clk, rst_n, s_tready |-> !mul_busy, "ready while multiplier busy")
    `APWA_ASSERT(a_done_in_run, clk, rst_n, mul_done |-> (st_reg == ST_RUN), "product outside run")
    `APWA_ASSERT(a_first_no_cross, clk, rst_n, (cnt_reg == '0) |-> (xc_reg == '0), "crossing without samples")
    `APWA_ASSERT_NEXT(a_go_runs, clk, rst_n, go, (st_reg == ST_RUN) && mul_busy, "measure did not start")
endmodule
`default_nettype wire
